// ===== sv/lidar_frame_parser_assert.svh =====
// assertion macros for the lidar frame parser
// clocked on clk, disabled while arst_n is low where noted
`ifndef LIDAR_FRAME_PARSER_ASSERT_SVH
`define LIDAR_FRAME_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF
`define LFP_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("lidar frame parser assertion failed");
`define LFP_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("lidar frame parser assertion failed");
`else
`define LFP_ASSERT(label, prop)
`define LFP_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== sv/lfp_pkg.sv =====
// shared types, constants and the crc-8 step of the lidar frame parser
// no dependencies
package lfp_pkg;

	localparam int POINTS_DEFAULT = 12;
	localparam int CFG_ADDR_W     = 8;
	localparam logic [15:0] ANGLE_WRAP = 16'd36000;

	localparam logic [7:0] POLY_RESET  = 8'h4D;
	localparam logic [7:0] SEED_RESET  = 8'hD8;
	localparam logic [7:0] HDR1_RESET  = 8'h54;
	localparam logic [7:0] HDR2_RESET  = 8'h2C;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_CRC_POLY = 8'd0,
		REG_CRC_SEED = 8'd1,
		REG_HDR1     = 8'd2,
		REG_HDR2     = 8'd3
	} reg_addr_t;

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_SECOND,
		PH_BODY,
		PH_CHECK,
		PH_DIVIDE,
		PH_READ,
		PH_LOAD
	} phase_t;

	// msb-first crc-8, no reflection
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b,
			input logic [7:0] poly);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ poly;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

// ===== sv/lfp_if.sv =====
// channel interfaces of the lidar frame parser: received bytes, points, register writes
// uses lfp_pkg for the register address width
interface lfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface lfp_point_if;
	logic        valid;
	logic        ready;
	logic [15:0] distance;
	logic [7:0]  intensity;
	logic [15:0] angle;
	logic [3:0]  point_index;
	logic [15:0] rotation_speed;
	logic [15:0] frame_time;
	logic        last_point;

	modport source (output valid, output distance, output intensity, output angle,
		output point_index, output rotation_speed, output frame_time, output last_point,
		input ready);
	modport sink (input valid, input distance, input intensity, input angle,
		input point_index, input rotation_speed, input frame_time, input last_point,
		output ready);
endinterface

interface lfp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lfp_pkg::CFG_ADDR_W-1:0] addr;
	logic [7:0]                    data;

	modport source (output valid, output addr, output data, input ready);
	modport sink (input valid, input addr, input data, output ready);
endinterface

// ===== sv/lidar_frame_parser.sv =====
// lidar frame parser: one received byte per transaction in, up to one point per transaction out.
// a byte is taken every cycle while hunting or collecting a frame; after a good check byte
// the input stalls for the angle step (reciprocal multiply) and then for a point memory read and
// an output register load per point, longer while points are stalled. the first point is loaded
// into the output register in PH_LOAD, after PH_DIVIDE and PH_READ. reset clears
// the sync state and loads the register reset values; point memory and frame fields need no reset.
`include "lidar_frame_parser_assert.svh"

module lidar_frame_parser #(
	parameter int POINTS_PER_FRAME = lfp_pkg::POINTS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	lfp_byte_if.sink   rx,
	lfp_point_if.source points,
	lfp_cfg_if.sink    cfg
);
	import lfp_pkg::*;

	localparam int BODY_LEN = 3 * POINTS_PER_FRAME + 8;
	localparam int PTS_END  = 4 + 3 * POINTS_PER_FRAME;
	localparam int PW       = $clog2(BODY_LEN + 1);
	localparam int IW       = $clog2(POINTS_PER_FRAME);
	localparam int DIVISOR  = POINTS_PER_FRAME - 1;
	// reciprocal of the divisor, exact for any 16-bit span
	localparam int LOG_DIV  = $clog2(DIVISOR);
	localparam int RSHIFT   = 16 + LOG_DIV;
	localparam int RECIP    = ((1 << RSHIFT) + DIVISOR - 1) / DIVISOR;

	// registers
	logic [7:0] poly_q, seed_q, hdr1_q, hdr2_q;

	phase_t phase_q, phase_d;
	logic rx_ready, rx_fire, mem_rd, load_out;

	logic [PW-1:0] pos_q;
	logic [1:0]    pt_sub_q;
	logic [IW-1:0] pt_idx_q;
	logic [15:0]   asm_q;
	logic [7:0]    crc_q;
	logic [15:0]   speed_q, start_q, end_q, stamp_q;

	logic [23:0]   point_mem [POINTS_PER_FRAME];
	logic [23:0]   rdata_q;

	logic [15:0]   num_q;
	logic [15:0]   step_mod_q;
	logic [15:0]   ang_q;
	logic [IW-1:0] emit_idx_q;

	logic        out_valid_q;
	logic [15:0] out_dist_q, out_ang_q, out_speed_q, out_stamp_q;
	logic [7:0]  out_int_q;
	logic [3:0]  out_idx_q;
	logic        out_last_q;

	logic [7:0] b;
	assign b = rx.rx_byte;

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q <= POLY_RESET;
			seed_q <= SEED_RESET;
			hdr1_q <= HDR1_RESET;
			hdr2_q <= HDR2_RESET;
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_CRC_POLY: poly_q <= cfg.data;
				REG_CRC_SEED: seed_q <= cfg.data;
				REG_HDR1:     hdr1_q <= cfg.data;
				REG_HDR2:     hdr2_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// angle span and reductions
	logic [16:0] diff_se;
	logic [15:0] span, start_mod, step_mod, ang_sum_red;
	logic [16:0] ang_sum;
	logic [47:0] step_prod;
	logic [15:0] step_quot;
	logic        last_idx;

	always_comb begin
		diff_se = {1'b0, start_q} - {1'b0, end_q};
		if (start_q <= end_q) begin
			span = end_q - start_q;
		end else if (diff_se <= {1'b0, ANGLE_WRAP}) begin
			span = 16'({1'b0, ANGLE_WRAP} - diff_se);
		end else begin
			span = '0;
		end
		start_mod = (start_q >= ANGLE_WRAP) ? (start_q - ANGLE_WRAP) : start_q;
		step_mod  = (num_q >= ANGLE_WRAP) ? (num_q - ANGLE_WRAP) : num_q;
		ang_sum   = {1'b0, ang_q} + {1'b0, step_mod_q};
		ang_sum_red = (ang_sum >= {1'b0, ANGLE_WRAP}) ? 16'(ang_sum - {1'b0, ANGLE_WRAP})
			: ang_sum[15:0];
		step_prod = 48'(num_q) * 48'(RECIP);
		step_quot = step_prod[RSHIFT +: 16];
		last_idx = (emit_idx_q == IW'(POINTS_PER_FRAME - 1));
	end

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		rx_ready = 1'b0;
		mem_rd   = 1'b0;
		load_out = 1'b0;
		case (phase_q)
			PH_FIRST: begin
				rx_ready = 1'b1;
				if (rx.valid && b == hdr1_q) phase_d = PH_SECOND;
			end
			PH_SECOND: begin
				rx_ready = 1'b1;
				if (rx.valid) begin
					if (b == hdr2_q) begin
						phase_d = PH_BODY;
					end else if (b != hdr1_q) begin
						phase_d = PH_FIRST;
					end
				end
			end
			PH_BODY: begin
				rx_ready = 1'b1;
				if (rx.valid && pos_q == PW'(BODY_LEN - 1)) phase_d = PH_CHECK;
			end
			PH_CHECK: begin
				rx_ready = 1'b1;
				if (rx.valid) phase_d = (b == crc_q) ? PH_DIVIDE : PH_FIRST;
			end
			PH_DIVIDE: begin
				phase_d = PH_READ;
			end
			PH_READ: begin
				mem_rd  = 1'b1;
				phase_d = PH_LOAD;
			end
			PH_LOAD: begin
				if (!out_valid_q || points.ready) begin
					load_out = 1'b1;
					phase_d  = last_idx ? PH_FIRST : PH_READ;
				end
			end
			default: phase_d = PH_FIRST;
		endcase
	end

	assign rx.ready = rx_ready;
	assign rx_fire  = rx.valid && rx_ready;

	// body counters and crc
	logic in_points;
	assign in_points = (pos_q >= PW'(4)) && (pos_q < PW'(PTS_END));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			pt_sub_q <= '0;
			pt_idx_q <= '0;
			crc_q    <= '0;
		end else if (rx_fire) begin
			if (phase_q == PH_SECOND && b == hdr2_q) begin
				pos_q    <= '0;
				pt_sub_q <= '0;
				pt_idx_q <= '0;
				crc_q    <= seed_q;
			end else if (phase_q == PH_BODY) begin
				pos_q <= pos_q + PW'(1);
				crc_q <= crc8_update(crc_q, b, poly_q);
				if (in_points) begin
					if (pt_sub_q == 2'd2) begin
						pt_sub_q <= '0;
						pt_idx_q <= pt_idx_q + IW'(1);
					end else begin
						pt_sub_q <= pt_sub_q + 2'd1;
					end
				end
			end else if (phase_q == PH_CHECK) begin
				pos_q <= '0;
			end
		end
	end

	// frame fields, little endian
	logic [PW-1:0] rel_tail;
	assign rel_tail = pos_q - PW'(PTS_END);

	always_ff @(posedge clk) begin
		if (rx_fire && phase_q == PH_BODY) begin
			if (pos_q < PW'(2)) begin
				if (pos_q[0]) speed_q[15:8] <= b; else speed_q[7:0] <= b;
			end else if (pos_q < PW'(4)) begin
				if (pos_q[0]) start_q[15:8] <= b; else start_q[7:0] <= b;
			end else if (in_points) begin
				if (pt_sub_q == 2'd0) asm_q[7:0] <= b;
				if (pt_sub_q == 2'd1) asm_q[15:8] <= b;
			end else if (pos_q < PW'(PTS_END + 2)) begin
				if (rel_tail[0]) end_q[15:8] <= b; else end_q[7:0] <= b;
			end else begin
				if (rel_tail[0]) stamp_q[15:8] <= b; else stamp_q[7:0] <= b;
			end
		end
	end

	// point memory: whole entry written on the intensity byte
	always_ff @(posedge clk) begin
		if (rx_fire && phase_q == PH_BODY && in_points && pt_sub_q == 2'd2) begin
			point_mem[pt_idx_q] <= {b, asm_q};
		end
		if (mem_rd) begin
			rdata_q <= point_mem[emit_idx_q];
		end
	end

	// point counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_idx_q <= '0;
		end else begin
			if (rx_fire && phase_q == PH_CHECK) begin
				emit_idx_q <= '0;
			end else if (load_out) begin
				emit_idx_q <= emit_idx_q + IW'(1);
			end
		end
	end

	// angle step by reciprocal multiply, then the angle walk
	always_ff @(posedge clk) begin
		if (rx_fire && phase_q == PH_CHECK) begin
			num_q <= span;
			ang_q <= start_mod;
		end else if (phase_q == PH_DIVIDE) begin
			num_q <= step_quot;
		end else if (load_out) begin
			ang_q <= ang_sum_red;
		end
		if (phase_q == PH_READ) begin
			step_mod_q <= step_mod;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (points.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_dist_q  <= rdata_q[15:0];
			out_int_q   <= rdata_q[23:16];
			out_ang_q   <= ang_q;
			out_idx_q   <= 4'(emit_idx_q);
			out_speed_q <= speed_q;
			out_stamp_q <= stamp_q;
			out_last_q  <= last_idx;
		end
	end

	assign points.valid          = out_valid_q;
	assign points.distance       = out_dist_q;
	assign points.intensity      = out_int_q;
	assign points.angle          = out_ang_q;
	assign points.point_index    = out_idx_q;
	assign points.rotation_speed = out_speed_q;
	assign points.frame_time     = out_stamp_q;
	assign points.last_point     = out_last_q;

	`LFP_ASSERT(a_angle_range, points.valid |-> (points.angle < ANGLE_WRAP))
	`LFP_ASSERT(a_last_index, (points.valid && points.last_point) |-> (points.point_index == 4'(POINTS_PER_FRAME - 1)))
	`LFP_ASSERT(a_pos_range, (phase_q == PH_BODY) |-> (pos_q < PW'(BODY_LEN)))
	`LFP_ASSERT(a_load_after_read, (phase_q == PH_LOAD) |-> ($past(phase_q) == PH_READ || $past(phase_q) == PH_LOAD))
	`LFP_ASSERT_ALWAYS(a_no_input_while_emit, (phase_q == PH_DIVIDE || phase_q == PH_READ || phase_q == PH_LOAD) |-> !rx.ready)

endmodule

// ===== tb/sv/lidar_frame_parser_tb.sv =====
// self-checking bench for lidar_frame_parser: drives received bytes, writes the registers
// between phases and checks every emitted point against a frame decoder kept in step
// depends on lfp_pkg, lfp_if.sv and the parser rtl
module lidar_frame_parser_tb;
	import lfp_pkg::*;

	localparam int NPTS        = POINTS_DEFAULT;
	localparam int BODY_BYTES  = 3 * NPTS + 8;
	localparam int DRAIN_TICKS = 16 + 2 * NPTS + 24;
	localparam int unsigned WRAP = ANGLE_WRAP;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 8'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 8'hFF;

	// point content styles for a frame
	localparam int PTS_RANDOM = 0;
	localparam int PTS_ONES   = 1;
	localparam int PTS_ZEROS  = 2;

	typedef struct packed {
		logic [15:0] distance;
		logic [7:0]  intensity;
		logic [15:0] angle;
		logic [3:0]  point_index;
		logic [15:0] rotation_speed;
		logic [15:0] frame_time;
		logic        last_point;
	} lidar_point_t;

	class frame_decoder;
		bit [7:0] poly, seed, hdr1, hdr2;
		phase_t phase;
		int body_pos;
		bit [7:0] crc;
		bit [15:0] speed, start_ang, end_ang, stamp;
		bit [23:0] pts[NPTS];
		lidar_point_t due_points[$];
		int fails;
		int frames_ok;

		function new();
			poly = POLY_RESET;
			seed = SEED_RESET;
			hdr1 = HDR1_RESET;
			hdr2 = HDR2_RESET;
			phase = PH_FIRST;
			body_pos = 0;
			crc = 8'h00;
			fails = 0;
			frames_ok = 0;
		endfunction

		function void set_reg(logic [CFG_ADDR_W-1:0] idx, bit [7:0] v);
			if (idx == REG_CRC_POLY) poly = v;
			else if (idx == REG_CRC_SEED) seed = v;
			else if (idx == REG_HDR1) hdr1 = v;
			else if (idx == REG_HDR2) hdr2 = v;
		endfunction

		function bit [7:0] crc_next(bit [7:0] c, bit [7:0] b);
			bit [7:0] r;
			r = c ^ b;
			repeat (8) r = r[7] ? ((r << 1) ^ poly) : (r << 1);
			return r;
		endfunction

		function void store_body(int pos, bit [7:0] b);
			int rel;
			if (pos < 2) begin
				speed[pos*8 +: 8] = b;
			end else if (pos < 4) begin
				start_ang[(pos-2)*8 +: 8] = b;
			end else if (pos < 4 + 3*NPTS) begin
				rel = pos - 4;
				pts[rel/3][(rel%3)*8 +: 8] = b;
			end else if (pos < 6 + 3*NPTS) begin
				end_ang[(pos-4-3*NPTS)*8 +: 8] = b;
			end else begin
				stamp[(pos-6-3*NPTS)*8 +: 8] = b;
			end
		endfunction

		function void emit_frame();
			int unsigned s, e, span, stp;
			lidar_point_t p;
			s = start_ang;
			e = end_ang;
			if (s <= e) span = e - s;
			else if (s - e <= WRAP) span = WRAP - (s - e);
			else span = 0;
			stp = span / (NPTS - 1);
			for (int i = 0; i < NPTS; i++) begin
				p.distance = pts[i][15:0];
				p.intensity = pts[i][23:16];
				p.angle = 16'((s + stp * i) % WRAP);
				p.point_index = 4'(i);
				p.rotation_speed = speed;
				p.frame_time = stamp;
				p.last_point = (i == NPTS - 1);
				due_points = {due_points, p};
			end
			frames_ok++;
		endfunction

		function void take_byte(bit [7:0] b);
			case (phase)
				PH_FIRST: begin
					if (b == hdr1) phase = PH_SECOND;
				end
				PH_SECOND: begin
					if (b == hdr2) begin
						phase = PH_BODY;
						body_pos = 0;
						crc = seed;
					end else if (b != hdr1) begin
						phase = PH_FIRST;
					end
				end
				PH_BODY: begin
					store_body(body_pos, b);
					crc = crc_next(crc, b);
					body_pos++;
					if (body_pos >= BODY_BYTES) phase = PH_CHECK;
				end
				default: begin
					phase = PH_FIRST;
					body_pos = 0;
					if (b == crc) emit_frame();
				end
			endcase
		endfunction

		task report(string what);
			fails++;
			if (fails <= 40) $display("mismatch: %s", what);
		endtask

		task check_field(string name, int unsigned got, int unsigned want);
			if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
		endtask

		task compare_point(lidar_point_t got);
			lidar_point_t want;
			if (due_points.size() == 0) begin
				report($sformatf("point %0d arrived with no frame pending", got.point_index));
			end else begin
				want = due_points.pop_front();
				check_field("distance", got.distance, want.distance);
				check_field("intensity", got.intensity, want.intensity);
				check_field("angle", got.angle, want.angle);
				check_field("point_index", got.point_index, want.point_index);
				check_field("rotation_speed", got.rotation_speed, want.rotation_speed);
				check_field("frame_time", got.frame_time, want.frame_time);
				check_field("last_point", got.last_point, want.last_point);
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	lfp_byte_if  rx_ch();
	lfp_point_if pt_ch();
	lfp_cfg_if   cfg_ch();

	lidar_frame_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.points(pt_ch),
		.cfg(cfg_ch)
	);

	frame_decoder dec = new();

	int burst_left = 0;
	bit steady_send = 0;
	int bytes_sent = 0;
	int stall_mode = 0;
	int tick = 0;
	bit [7:0] ready_pattern = 8'hFF;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	// point receiver: check each transaction, then pick ready for the next cycle
	always @(posedge clk) begin : point_rx
		lidar_point_t got;
		if (pt_ch.valid === 1'b1 && pt_ch.ready === 1'b1) begin
			got.distance = pt_ch.distance;
			got.intensity = pt_ch.intensity;
			got.angle = pt_ch.angle;
			got.point_index = pt_ch.point_index;
			got.rotation_speed = pt_ch.rotation_speed;
			got.frame_time = pt_ch.frame_time;
			got.last_point = pt_ch.last_point;
			dec.compare_point(got);
		end
		tick++;
		if (tick % 173 == 0) begin
			stall_mode = $urandom_range(0, 3);
			ready_pattern = 8'($urandom_range(1, 255));
		end
		case (stall_mode)
			0: pt_ch.ready <= 1'b1;
			1: pt_ch.ready <= ($urandom_range(0, 3) != 0);
			2: pt_ch.ready <= ready_pattern[tick % 8];
			default: pt_ch.ready <= ((tick % 40) > 24);
		endcase
	end

	task send_byte(input bit [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = steady_send ? 0 : $urandom_range(0, 6);
			if (!steady_send && $urandom_range(0, 15) == 0) gap = $urandom_range(10, 40);
			if (gap > 0) begin
				rx_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		rx_ch.valid <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (rx_ch.ready !== 1'b1) @(posedge clk);
		dec.take_byte(b);
		burst_left--;
		bytes_sent++;
	endtask

	// stop sending and let every pending point and any trailing work finish
	task drain();
		rx_ch.valid <= 1'b0;
		burst_left = 0;
		while (dec.due_points.size() != 0) @(posedge clk);
		repeat (DRAIN_TICKS) @(posedge clk);
	endtask

	task write_reg(input logic [CFG_ADDR_W-1:0] idx, input bit [7:0] v, input bit last);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr <= idx;
		cfg_ch.data <= v;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1) @(posedge clk);
		dec.set_reg(idx, v);
		if (last) cfg_ch.valid <= 1'b0;
	endtask

	task apply_settings(input bit [7:0] p, input bit [7:0] s, input bit [7:0] h1,
			input bit [7:0] h2);
		write_reg(REG_CRC_POLY, p, 1'b0);
		write_reg(REG_CRC_SEED, s, 1'b0);
		write_reg(REG_HDR1, h1, 1'b0);
		write_reg(REG_SPARE_LO, 8'($urandom), 1'b0);
		write_reg(REG_SPARE_HI, 8'($urandom), 1'b0);
		write_reg(REG_HDR2, h2, 1'b1);
	endtask

	// split > 0: drain after that many body bytes and swap polynomial and seed mid-frame
	task send_frame(input bit [15:0] spd, input bit [15:0] sa, input bit [15:0] ea,
			input bit [15:0] ts, input int pts_style, input bit good_crc, input int split);
		bit [7:0] body[BODY_BYTES];
		bit [7:0] chk;
		body[0] = spd[7:0];
		body[1] = spd[15:8];
		body[2] = sa[7:0];
		body[3] = sa[15:8];
		for (int i = 4; i < 4 + 3*NPTS; i++) begin
			case (pts_style)
				PTS_ONES: body[i] = 8'hFF;
				PTS_ZEROS: body[i] = 8'h00;
				default: body[i] = 8'($urandom);
			endcase
		end
		body[4 + 3*NPTS] = ea[7:0];
		body[5 + 3*NPTS] = ea[15:8];
		body[6 + 3*NPTS] = ts[7:0];
		body[7 + 3*NPTS] = ts[15:8];
		send_byte(dec.hdr1);
		send_byte(dec.hdr2);
		for (int i = 0; i < BODY_BYTES; i++) begin
			if (split > 0 && i == split) begin
				drain();
				write_reg(REG_CRC_POLY, 8'($urandom), 1'b0);
				write_reg(REG_CRC_SEED, 8'($urandom), 1'b1);
			end
			send_byte(body[i]);
		end
		chk = dec.crc;
		if (!good_crc) chk = chk ^ 8'($urandom_range(1, 255));
		send_byte(chk);
	endtask

	function bit [15:0] pick_angle();
		if ($urandom_range(0, 5) == 0) return 16'($urandom);
		return 16'($urandom_range(0, WRAP - 1));
	endfunction

	task random_phase(input int min_bytes);
		int start_bytes;
		int start_frames;
		int pick;
		int n;
		start_bytes = bytes_sent;
		start_frames = dec.frames_ok;
		steady_send = ($urandom_range(0, 3) == 0);
		while (bytes_sent - start_bytes < min_bytes || dec.frames_ok == start_frames) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				// line noise, sometimes a lone first sync byte
				n = $urandom_range(1, 6);
				repeat (n) send_byte($urandom_range(0, 4) == 0 ? dec.hdr1 : 8'($urandom));
			end else if (pick == 1) begin
				// truncated frame: header then part of a body
				send_byte(dec.hdr1);
				send_byte(dec.hdr2);
				n = $urandom_range(0, BODY_BYTES - 1);
				repeat (n) send_byte(8'($urandom));
			end else begin
				send_frame(16'($urandom), pick_angle(), pick_angle(), 16'($urandom),
					PTS_RANDOM, pick != 2, 0);
			end
		end
		steady_send = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= 8'h00;
		cfg_ch.valid <= 1'b0;
		cfg_ch.addr <= 8'h00;
		cfg_ch.data <= 8'h00;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset register values
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(16'hFFFF, 16'd0, 16'd35999, 16'h0000, PTS_ONES, 1'b1, 0);
		// start beyond end by more than a full turn
		send_frame(16'h1234, 16'hFFFF, 16'h0000, 16'h5678, PTS_ZEROS, 1'b1, 0);
		send_frame(16'h0101, 16'd100, 16'd200, 16'h0202, PTS_RANDOM, 1'b0, 0);
		// wrong second byte, then a repeated first byte that still syncs
		send_byte(dec.hdr1);
		send_byte(8'h00);
		send_byte(dec.hdr1);
		send_frame(16'hA5A5, 16'd35999, 16'd0, 16'h5A5A, PTS_RANDOM, 1'b1, 20);
		drain();

		apply_settings(8'h00, 8'h00, 8'hFF, 8'h00);
		random_phase(40);
		drain();
		apply_settings(8'h07, 8'h5A, 8'hA5, 8'hA5);
		random_phase(40);
		drain();

		if (dec.due_points.size() != 0)
			dec.report($sformatf("%0d points never arrived", dec.due_points.size()));
		if (dec.fails == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/lfp_pkg.sv
sv/lfp_if.sv
sv/lidar_frame_parser.sv
tb/sv/lidar_frame_parser_tb.sv
